// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the stack evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define RPN_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define RPN_NEVER(lbl, clk, rst_n, cond) \
	`RPN_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define RPN_ASSERT(lbl, clk, rst_n, prop)
`define RPN_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/rpn_pkg.sv =====
// Types, codes and constants of the stack evaluator.
package rpn_pkg;

	localparam int STACK_DEPTH_DEF = 128;
	localparam int WORD_W          = 32;
	localparam int TOKEN_W         = 8;
	localparam int STATUS_W        = 3;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [TOKEN_W-1:0]  token_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Result status codes
	localparam status_t ST_ACCEPTED    = 3'd0;
	localparam status_t ST_VALUE       = 3'd1;
	localparam status_t ST_TOO_COMPLEX = 3'd2;
	localparam status_t ST_TOO_FEW     = 3'd3;
	localparam status_t ST_DIV_ZERO    = 3'd4;
	localparam status_t ST_END         = 3'd5;

	// Token characters
	localparam token_t TOK_TAB   = 8'd9;
	localparam token_t TOK_CR    = 8'd13;
	localparam token_t TOK_SPACE = 8'd32;
	localparam token_t TOK_ZERO  = 8'd48;
	localparam token_t TOK_NINE  = 8'd57;
	localparam token_t TOK_PLUS  = 8'h2B;
	localparam token_t TOK_MINUS = 8'h2D;
	localparam token_t TOK_STAR  = 8'h2A;
	localparam token_t TOK_SLASH = 8'h2F;
	localparam token_t TOK_EQUAL = 8'h3D;

	// Binary operations
	typedef logic [1:0] op_t;
	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_DIV = 2'd3;

endpackage

// ===== rtl/rpn_if.sv =====
// Token and result channel interfaces of the stack evaluator.
interface rpn_tok_if;
	import rpn_pkg::*;
	logic   valid;
	logic   ready;
	token_t token;

	modport source (output valid, output token, input ready);
	modport sink (input valid, input token, output ready);
endinterface

interface rpn_res_if;
	import rpn_pkg::*;
	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [31:0] value;

	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);
endinterface

// ===== rtl/rpn_stk_mem.sv =====
// Operand stack memory: one write port, one read port with registered data.
module rpn_stk_mem #(
	parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  rpn_pkg::word_t    wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output rpn_pkg::word_t    rdata
);
	import rpn_pkg::*;

	word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rpn_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`include "assert_macros.svh"

module rpn_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rpn_pkg::word_t dividend,
	input  rpn_pkg::word_t divisor,
	output logic           done,
	output rpn_pkg::word_t quotient
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(WORD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            rem_q;
	word_t            quo_q;
	word_t            ub_q;
	logic             neg_q;

	logic [WORD_W:0]   shifted;
	logic [WORD_W+1:0] trial;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, ub_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
			ub_q  <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q) begin
			// restore on borrow, otherwise keep the difference
			if (!trial[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

	`RPN_NEVER(a_div_start_busy, clk, arst_n, start && busy_q)
	`RPN_NEVER(a_div_done_busy, clk, arst_n, done_q && busy_q)
	`RPN_ASSERT(a_div_cnt_live, clk, arst_n, busy_q |-> (cnt_q != CNT_W'(0)))

endmodule

// ===== rtl/rpn_stack_evaluator_core.sv =====
// Reverse Polish stack evaluator: token decode, sequencer and result register.
//
//   channel | dir | payload              | transaction
//   tok     | in  | token[7:0]           | valid & ready
//   res     | out | status[2:0], value   | valid & ready
//
// One token at a time. Whitespace, digits, stack errors and end go straight to
// the emit step; '=' reads the top first; '+' '-' '*' take two stack memory
// reads and a write-back; '/' with a zero divisor stops after the reads, and any
// other '/' waits for the divider, one quotient bit per cycle, before its write-back.
// Reset clears the sequencer, the stack count and the result valid; the
// stack memory is not cleared. A token is taken while an earlier result
// still waits; a stalled result holds the sequencer in its emit step.
`include "assert_macros.svh"

module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rpn_tok_if.sink   tok,
	rpn_res_if.source res
);
	import rpn_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDB  = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_RDV  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_v_q, out_v_d;
	op_t           op_q, op_d;
	word_t         b_q, b_d;
	word_t         r_q, r_d;
	status_t       pst_q, pst_d;
	word_t         pval_q, pval_d;
	status_t       ost_q, ost_d;
	word_t         oval_q, oval_d;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	word_t         mem_wdata, mem_rdata;

	logic          div_start, div_done;
	word_t         div_q;

	logic          tok_acc;
	logic          emit_go;
	logic          is_space, is_digit, is_op;

	rpn_stk_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mem_rdata),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign tok.ready = (state_q == S_IDLE);
	assign tok_acc   = tok.valid && (state_q == S_IDLE);
	assign emit_go   = (state_q == S_EMIT) && (!out_v_q || res.ready);

	assign is_space = (tok.token == TOK_SPACE) ||
		((tok.token >= TOK_TAB) && (tok.token <= TOK_CR));
	assign is_digit = (tok.token >= TOK_ZERO) && (tok.token <= TOK_NINE);
	assign is_op    = (tok.token == TOK_PLUS) || (tok.token == TOK_MINUS) ||
		(tok.token == TOK_STAR) || (tok.token == TOK_SLASH);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		out_v_d   = out_v_q && !res.ready;
		op_d      = op_q;
		b_d       = b_q;
		r_d       = r_q;
		pst_d     = pst_q;
		pval_d    = pval_q;
		ost_d     = ost_q;
		oval_d    = oval_q;
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = r_q;
		mem_re    = 1'b0;
		mem_raddr = AW'(cnt_q - CW'(1));
		div_start = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (tok_acc) begin
					pst_d   = ST_ACCEPTED;
					pval_d  = '0;
					state_d = S_EMIT;
					priority if (is_space) begin
						pst_d = ST_ACCEPTED;
					end else if (is_digit) begin
						if (cnt_q >= CW'(STACK_DEPTH)) begin
							cnt_d = '0;
							pst_d = ST_TOO_COMPLEX;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = WORD_W'(tok.token - TOK_ZERO);
							cnt_d     = cnt_q + CW'(1);
						end
					end else if (is_op) begin
						priority if (tok.token == TOK_PLUS) begin
							op_d = OP_ADD;
						end else if (tok.token == TOK_MINUS) begin
							op_d = OP_SUB;
						end else if (tok.token == TOK_STAR) begin
							op_d = OP_MUL;
						end else begin
							op_d = OP_DIV;
						end
						if (cnt_q < CW'(2)) begin
							cnt_d = '0;
							pst_d = ST_TOO_FEW;
						end else begin
							// fetch the right operand from the top
							mem_re  = 1'b1;
							state_d = S_RDB;
						end
					end else if (tok.token == TOK_EQUAL) begin
						if (cnt_q == CW'(0)) begin
							pst_d = ST_TOO_FEW;
						end else begin
							mem_re  = 1'b1;
							state_d = S_RDV;
						end
					end else begin
						cnt_d = '0;
						pst_d = ST_END;
					end
				end
			end
			S_RDB: begin
				b_d       = mem_rdata;
				mem_re    = 1'b1;
				mem_raddr = AW'(cnt_q - CW'(2));
				state_d   = S_RDA;
			end
			S_RDA: begin
				state_d = S_WB;
				unique case (op_q)
					OP_ADD: r_d = mem_rdata + b_q;
					OP_SUB: r_d = mem_rdata - b_q;
					OP_MUL: r_d = WORD_W'(mem_rdata * b_q);
					OP_DIV: begin
						if (b_q == '0) begin
							cnt_d   = '0;
							pst_d   = ST_DIV_ZERO;
							state_d = S_EMIT;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					r_d     = div_q;
					state_d = S_WB;
				end
			end
			S_WB: begin
				// drop the right operand, replace the left one
				mem_we    = 1'b1;
				mem_waddr = AW'(cnt_q - CW'(2));
				mem_wdata = r_q;
				cnt_d     = cnt_q - CW'(1);
				state_d   = S_EMIT;
			end
			S_RDV: begin
				pval_d  = mem_rdata;
				pst_d   = ST_VALUE;
				cnt_d   = cnt_q - CW'(1);
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_go) begin
					out_v_d = 1'b1;
					ost_d   = pst_q;
					oval_d  = pval_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		b_q    <= b_d;
		r_q    <= r_d;
		pst_q  <= pst_d;
		pval_q <= pval_d;
		ost_q  <= ost_d;
		oval_q <= oval_d;
	end

	assign res.valid  = out_v_q;
	assign res.status = ost_q;
	assign res.value  = oval_q;

	`RPN_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(STACK_DEPTH))
	`RPN_ASSERT(a_wb_depth, clk, arst_n, (state_q == S_WB) |-> (cnt_q >= CW'(2)))
	`RPN_ASSERT(a_div_done_wait, clk, arst_n, div_done |-> (state_q == S_DIV))
	`RPN_ASSERT(a_emit_load, clk, arst_n, emit_go |=> (out_v_q && (state_q == S_IDLE)))

endmodule

// ===== verif/rpn_stack_evaluator_core_tb.sv =====
// Self-checking testbench for the reverse Polish stack evaluator core.
module rpn_stack_evaluator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpn_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 6;
	localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int QUIET_LIMIT  = 2000;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		status_t status;
		word_t   value;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	rpn_tok_if tok_ch();
	rpn_res_if res_ch();

	rpn_stack_evaluator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_ch),
		.res    (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	token_t     pending_tokens[$];
	outcome_t   pending_outcomes[$];
	word_t      operand_words[STACK_DEPTH];
	int         word_count = 0;
	int         counted_tokens = 0;
	int         failures = 0;
	int         quiet_cycles = 0;
	idle_mode_t idle_mode = IDLE_NONE;
	logic       pressure_go = 1'b0;
	logic       hold_off = 1'b0;

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit is_blank(input token_t t);
		return t == TOK_SPACE || (t >= TOK_TAB && t <= TOK_CR);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		failures++;
	endtask

	// Advance the evaluator state by one token and give the result it must report.
	function automatic outcome_t apply_token(input token_t t);
		outcome_t o;
		word_t    a;
		word_t    b;
		word_t    r;
		word_t    mag_a;
		word_t    mag_b;
		word_t    quot;
		o.status = ST_ACCEPTED;
		o.value = '0;
		if (is_blank(t))
			return o;
		if (t >= TOK_ZERO && t <= TOK_NINE) begin
			if (word_count >= STACK_DEPTH) begin
				word_count = 0;
				o.status = ST_TOO_COMPLEX;
			end else begin
				operand_words[word_count] = word_t'(t - TOK_ZERO);
				word_count++;
			end
			return o;
		end
		if (t == TOK_PLUS || t == TOK_MINUS || t == TOK_STAR || t == TOK_SLASH) begin
			if (word_count < 2) begin
				word_count = 0;
				o.status = ST_TOO_FEW;
				return o;
			end
			b = operand_words[word_count - 1];
			a = operand_words[word_count - 2];
			case (t)
				TOK_PLUS:  r = a + b;
				TOK_MINUS: r = a - b;
				TOK_STAR:  r = a * b;
				default: begin
					if (b == '0) begin
						word_count = 0;
						o.status = ST_DIV_ZERO;
						return o;
					end
					// truncate toward zero: divide magnitudes, then fix the sign
					mag_a = a[WORD_W-1] ? -a : a;
					mag_b = b[WORD_W-1] ? -b : b;
					quot = mag_a / mag_b;
					r = (a[WORD_W-1] ^ b[WORD_W-1]) ? -quot : quot;
				end
			endcase
			word_count--;
			operand_words[word_count - 1] = r;
			return o;
		end
		if (t == TOK_EQUAL) begin
			if (word_count == 0) begin
				o.status = ST_TOO_FEW;
				return o;
			end
			word_count--;
			o.status = ST_VALUE;
			o.value = operand_words[word_count];
			return o;
		end
		word_count = 0;
		o.status = ST_END;
		return o;
	endfunction

	// Token driver: hold the current transaction until taken, then load the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.valid <= 1'b0;
			tok_ch.token <= '0;
		end else begin
			if (tok_ch.valid && tok_ch.ready)
				pending_outcomes.push_back(apply_token(tok_ch.token));
			if (!tok_ch.valid || tok_ch.ready) begin
				if (pending_tokens.size() != 0 &&
				    !((idle_mode == IDLE_SEND && roll(66)) ||
				      (idle_mode == IDLE_BOTH && roll(33)))) begin
					tok_ch.valid <= 1'b1;
					tok_ch.token <= pending_tokens.pop_front();
				end else begin
					tok_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transaction with the oldest expected outcome.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d value %0d",
						res_ch.status, res_ch.value));
				end else begin
					want = pending_outcomes.pop_front();
					if (res_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							res_ch.status, want.status));
					if (res_ch.value !== want.value)
						report_mismatch($sformatf("value %0d, expected %0d",
							res_ch.value, $signed(want.value)));
				end
			end
			res_ch.ready <= !(hold_off ||
				(idle_mode == IDLE_RECV && roll(66)) ||
				(idle_mode == IDLE_BOTH && roll(33)));
		end
	end

	// Long receiver hold-off, so the core fills up and stalls its token input.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic add_token(input token_t t);
		pending_tokens.push_back(t);
		if (!is_blank(t))
			counted_tokens++;
	endtask

	function automatic token_t rand_digit();
		return TOK_ZERO + token_t'($urandom_range(0, 9));
	endfunction

	function automatic token_t rand_op();
		case ($urandom_range(0, 3))
			0: return TOK_PLUS;
			1: return TOK_MINUS;
			2: return TOK_STAR;
			default: return TOK_SLASH;
		endcase
	endfunction

	function automatic token_t rand_blank();
		if (roll(50))
			return TOK_SPACE;
		return TOK_TAB + token_t'($urandom_range(0, 4));
	endfunction

	// Well-formed expression with random operands and operators, closed by '='.
	task automatic add_expression();
		int operands;
		int pushed;
		int depth;
		operands = $urandom_range(1, 8);
		pushed = 0;
		depth = 0;
		while (pushed < operands || depth > 1) begin
			if (pushed < operands && (depth < 2 || roll(50))) begin
				add_token(rand_digit());
				pushed++;
				depth++;
			end else begin
				add_token(rand_op());
				depth--;
			end
			if (roll(15))
				add_token(rand_blank());
		end
		add_token(TOK_EQUAL);
	endtask

	// Chain of large products, sums and differences that can wrap past the word range.
	task automatic add_wrap_chain();
		int steps;
		steps = $urandom_range(4, 14);
		add_token(TOK_NINE);
		repeat (steps) begin
			add_token(TOK_ZERO + token_t'($urandom_range(5, 9)));
			add_token(roll(75) ? TOK_STAR : (roll(50) ? TOK_PLUS : TOK_MINUS));
		end
		add_token(TOK_EQUAL);
	endtask

	// Build the most negative word as 8^10 * 2, then divide it by -1.
	task automatic add_min_by_minus_one();
		add_token(TOK_ZERO + 8'd8);
		repeat (9) begin
			add_token(TOK_ZERO + 8'd8);
			add_token(TOK_STAR);
		end
		add_token(TOK_ZERO + 8'd2);
		add_token(TOK_STAR);
		add_token(TOK_ZERO);
		add_token(TOK_ZERO + 8'd1);
		add_token(TOK_MINUS);
		add_token(TOK_SLASH);
		add_token(TOK_EQUAL);
	endtask

	task automatic add_random_traffic(input int quota);
		int start;
		int pick;
		start = counted_tokens;
		while (counted_tokens - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				add_expression();
			end else if (pick < 70) begin
				add_wrap_chain();
			end else if (pick < 73) begin
				add_min_by_minus_one();
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 4))
					add_token(token_t'($urandom_range(0, 255)));
			end else begin
				// broken sequences: stray operators, '=' and end bytes
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 2))
						0: add_token(rand_op());
						1: add_token(TOK_EQUAL);
						default: add_token(token_t'($urandom_range(128, 255)));
					endcase
				end
			end
		end
	endtask

	// Fill the stack to the top, fold it back down, then overfill it.
	task automatic add_deep_stack();
		add_token(8'hFF);
		repeat (STACK_DEPTH) add_token(TOK_ZERO + token_t'($urandom_range(1, 9)));
		repeat (STACK_DEPTH - 1) add_token(roll(70) ? TOK_PLUS : rand_op());
		add_token(TOK_EQUAL);
		add_token(8'hFF);
		repeat (STACK_DEPTH + 1) add_token(rand_digit());
		add_token(TOK_EQUAL);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_tokens.size() != 0 || tok_ch.valid || pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		tok_ch.valid = 1'b0;
		tok_ch.token = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: blanks, digit extremes, every operator and the too-few, divide-by-zero and end paths
		add_token(TOK_SPACE);
		add_token(TOK_TAB);
		add_token(TOK_CR);
		add_token(TOK_ZERO);
		add_token(TOK_NINE);
		add_token(TOK_PLUS);
		add_token(TOK_EQUAL);
		add_token(TOK_EQUAL);
		add_token(TOK_ZERO + 8'd5);
		add_token(TOK_PLUS);
		add_token(TOK_ZERO + 8'd5);
		add_token(TOK_ZERO);
		add_token(TOK_SLASH);
		add_token(TOK_ZERO + 8'd7);
		add_token(TOK_ZERO + 8'd3);
		add_token(TOK_MINUS);
		add_token(TOK_ZERO + 8'd4);
		add_token(TOK_STAR);
		add_token(TOK_EQUAL);
		add_token(TOK_ZERO + 8'd1);
		add_token(TOK_ZERO + 8'd2);
		add_token(TOK_EQUAL);
		add_token(TOK_EQUAL);
		add_token(8'hFF);
		wait_idle();

		add_random_traffic(PHASE_ITEMS);
		wait_idle();
		idle_mode = IDLE_SEND;
		add_random_traffic(PHASE_ITEMS);
		wait_idle();
		idle_mode = IDLE_RECV;
		add_random_traffic(PHASE_ITEMS);
		wait_idle();
		idle_mode = IDLE_BOTH;
		add_random_traffic(PHASE_ITEMS);
		wait_idle();

		idle_mode = IDLE_NONE;
		add_deep_stack();
		add_random_traffic(60);
		pressure_go = 1'b1;
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_outcomes.size()));
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
